FILE: design/ppi_pkg.sv
// Shared constants, types and tables for the planar pose integrator.
package ppi_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int CW = 34;
    typedef logic signed [CW-1:0] cdata_t;

    localparam logic [63:0]    INV_TWO_PI_Q64  = 64'h28BE60DB9391054A;
    localparam logic [31:0]    TWO_OVER_PI_Q32 = 32'hA2F9836E;
    localparam cdata_t         CORDIC_X0       = 34'sd652032874;
    localparam logic [62:0]    STEP_CAP        = 63'h4000000000000000;

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

endpackage

FILE: design/ppi_cordic.sv
// Iterative rotation-mode CORDIC that returns cosine and sine of a binary angle.
module ppi_cordic
    import ppi_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] angle,
    output logic        done,
    output cdata_t      cos_out,
    output cdata_t      sin_out
);

    localparam int SW = $clog2(STEPS + 1);

    logic          busy_reg;
    logic          flip_reg;
    logic [SW-1:0] idx_reg;
    cdata_t        x_reg;
    cdata_t        y_reg;
    cdata_t        z_reg;
    logic          done_reg;
    cdata_t        cos_reg;
    cdata_t        sin_reg;

    logic        fold;
    logic [31:0] a_fold;
    cdata_t      z_init;
    logic [4:0]  sh;
    cdata_t      xs;
    cdata_t      ys;
    cdata_t      at;
    cdata_t      x_next;
    cdata_t      y_next;
    cdata_t      z_next;
    logic        last_step;

    always_comb
    begin
        fold      = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
        a_fold    = fold ? (angle - 32'h80000000) : angle;
        z_init    = cdata_t'($signed(a_fold));
        sh        = 5'(idx_reg);
        xs        = x_reg >>> sh;
        ys        = y_reg >>> sh;
        at        = cdata_t'({2'b00, ATAN_BAM[sh]});
        if (!z_reg[CW-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
        last_step = (idx_reg == SW'(STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            flip_reg <= 1'b0;
            idx_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            done_reg <= 1'b0;
            cos_reg  <= '0;
            sin_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= CORDIC_X0;
                y_reg    <= '0;
                z_reg    <= z_init;
                flip_reg <= fold;
                idx_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                z_reg   <= z_next;
                idx_reg <= idx_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    cos_reg  <= flip_reg ? -x_next : x_next;
                    sin_reg  <= flip_reg ? -y_next : y_next;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

FILE: design/ppi_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module ppi_divider
    import ppi_pkg::*;
#(
    parameter int NW = 128,
    parameter int DW = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  num_reg;
    logic [DW-1:0]  den_reg;
    logic [DW-1:0]  rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        ge    = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= CNW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: design/planar_pose_integrator_top.sv
// Top level of the planar pose integrator: sequencer, shared multiplier and pose state.
//
// Each request either clears the pose or integrates one velocity sample over the time
// since the previous sample. A request runs through a small sequencer that drives one
// shared 32x32 multiplier with a 128-bit accumulator, an iterative CORDIC and a radix-2
// divider; upd_stall stays high until the result is registered. A clear request goes
// straight to the output register. A midpoint (near-straight) step is held up by the
// multiplier passes and one CORDIC run of CORDIC_STEPS iterations. An arc step is held
// up by the multiplier passes, two CORDIC runs and two divisions for the x and y steps.
// When the output register still holds a stalled result, the block waits for it.
// A finished result waits in the output register while the next request is accepted.
module planar_pose_integrator_top
    import ppi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd_valid,
    output logic               upd_stall,
    input  logic               mode,
    input  logic signed [31:0] fwd_speed,
    input  logic signed [31:0] yaw_rate,
    input  logic [47:0]        time_stamp,
    output logic               pose_valid,
    input  logic               pose_stall,
    output logic signed [47:0] pos_x,
    output logic signed [47:0] pos_y,
    output logic signed [31:0] heading,
    output logic signed [31:0] last_linear,
    output logic signed [31:0] last_angular,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);

    localparam int DA_SHIFT = FRAC_BITS + 52;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL, S_ACC, S_JOB, S_DECIDE,
        S_CMID, S_C0, S_C1, S_DX, S_DY, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        J_DL, J_W, J_K, J_MX, J_MY, J_AX1, J_AX2, J_AY1, J_AY2
    } job_t;

    state_t state_reg;
    job_t   job_reg;

    logic [15:0]        thr_reg;
    logic signed [47:0] x_reg;
    logic signed [47:0] y_reg;
    logic [31:0]        hd_reg;
    logic [47:0]        last_time_reg;
    logic [31:0]        sv_lin_reg;
    logic [31:0]        sv_ang_reg;
    logic [47:0]        now_reg;
    logic [31:0]        dt_reg;
    logic               dl_neg_reg;
    logic               da_neg_reg;
    logic [43:0]        dl_reg;
    logic [62:0]        da_reg;
    logic               sgn_reg;

    logic [95:0]  a_reg;
    logic [63:0]  b_reg;
    logic [1:0]   na_reg;
    logic         nb_reg;
    logic [1:0]   i_reg;
    logic         j_reg;
    logic [63:0]  prod_reg;
    logic [127:0] acc_reg;

    cdata_t       c0_reg;
    cdata_t       s0_reg;
    logic         cst_reg;
    logic [31:0]  cang_reg;
    logic         dst_reg;

    logic               out_valid_reg;
    logic signed [47:0] px_out_reg;
    logic signed [47:0] py_out_reg;
    logic signed [31:0] hd_out_reg;
    logic signed [31:0] lin_out_reg;
    logic signed [31:0] ang_out_reg;

    logic         cdone;
    cdata_t       cos_v;
    cdata_t       sin_v;
    logic         ddone;
    logic [127:0] quo_v;

    logic [47:0]  diff;
    logic         dneg;
    logic [47:0]  dmag48;
    logic [31:0]  dt_sat;
    logic [31:0]  vm;
    logic [31:0]  wm;
    logic [63:0]  dl_rnd;
    logic [127:0] k_rnd;
    logic [127:0] k_sh;
    logic [62:0]  da_sat;
    logic [31:0]  da_bits;
    logic         straight;
    logic [63:0]  half;
    logic [31:0]  dir;
    logic [62:0]  mid_mag;
    logic [62:0]  arc_mag;
    logic signed [CW:0] dsx;
    logic signed [CW:0] dsy;
    logic [31:0]  a_limb;
    logic [31:0]  b_limb;
    logic [2:0]   ksum;
    logic [127:0] shifted;
    logic         mul_last;
    logic         accept;

    function automatic logic [62:0] sat_cap(input logic [127:0] v);
        return (v > {65'd0, STEP_CAP}) ? STEP_CAP : v[62:0];
    endfunction

    function automatic logic [31:0] mag_c(input cdata_t v);
        logic [CW-1:0] m;
        m = v[CW-1] ? -v : v;
        return m[31:0];
    endfunction

    function automatic logic [31:0] mag_d(input logic signed [CW:0] v);
        logic [CW:0] m;
        m = v[CW] ? -v : v;
        return m[31:0];
    endfunction

    function automatic logic signed [47:0] add_pos(input logic signed [47:0] p,
                                                   input logic neg,
                                                   input logic [62:0] mag);
        logic signed [63:0] d;
        logic signed [63:0] s;
        d = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        s = $signed({{16{p[47]}}, p}) + d;
        if (s > 64'sd140737488355327)
            return 48'sh7FFFFFFFFFFF;
        else if (s < -64'sd140737488355328)
            return 48'sh800000000000;
        else
            return s[47:0];
    endfunction

    ppi_cordic #(
        .STEPS   (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cst_reg),
        .angle   (cang_reg),
        .done    (cdone),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    ppi_divider #(
        .NW    (128),
        .DW    (64)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dst_reg),
        .num   (acc_reg),
        .den   ({1'b0, da_reg}),
        .done  (ddone),
        .quo   (quo_v)
    );

    always_comb
    begin
        accept   = upd_valid && !upd_stall;
        diff     = now_reg - last_time_reg;
        dneg     = diff[47];
        dmag48   = dneg ? (48'd0 - diff) : diff;
        dt_sat   = (dmag48[47:32] != 16'd0) ? 32'hFFFFFFFF : dmag48[31:0];
        vm       = sv_lin_reg[31] ? (32'd0 - sv_lin_reg) : sv_lin_reg;
        wm       = sv_ang_reg[31] ? (32'd0 - sv_ang_reg) : sv_ang_reg;
        dl_rnd   = acc_reg[63:0] + 64'd524288;
        k_rnd    = acc_reg + (128'd1 << (DA_SHIFT - 1));
        k_sh     = k_rnd >> DA_SHIFT;
        da_sat   = sat_cap(k_sh);
        da_bits  = da_neg_reg ? (32'd0 - da_reg[31:0]) : da_reg[31:0];
        straight = (da_reg == '0) || (da_reg < 63'(thr_reg));
        half     = da_neg_reg ? ((64'(da_reg) + 64'd1) >> 1) : (64'(da_reg) >> 1);
        dir      = da_neg_reg ? (hd_reg - half[31:0]) : (hd_reg + half[31:0]);
        mid_mag  = sat_cap((acc_reg + 128'd536870912) >> 30);
        arc_mag  = sat_cap((quo_v + 128'h80000000) >> 32);
        dsx      = $signed({sin_v[CW-1], sin_v}) - $signed({s0_reg[CW-1], s0_reg});
        dsy      = $signed({c0_reg[CW-1], c0_reg}) - $signed({cos_v[CW-1], cos_v});
        unique case (i_reg)
            2'd0:    a_limb = a_reg[31:0];
            2'd1:    a_limb = a_reg[63:32];
            2'd2:    a_limb = a_reg[95:64];
            default: a_limb = 32'd0;
        endcase
        b_limb   = j_reg ? b_reg[63:32] : b_reg[31:0];
        ksum     = {1'b0, i_reg} + {2'b00, j_reg};
        unique case (ksum)
            3'd0:    shifted = {64'd0, prod_reg};
            3'd1:    shifted = {32'd0, prod_reg, 32'd0};
            3'd2:    shifted = {prod_reg, 64'd0};
            default: shifted = {prod_reg[31:0], 96'd0};
        endcase
        mul_last = (i_reg == na_reg) && (j_reg == nb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= J_DL;
            thr_reg       <= 16'd1;
            x_reg         <= '0;
            y_reg         <= '0;
            hd_reg        <= '0;
            last_time_reg <= '0;
            sv_lin_reg    <= '0;
            sv_ang_reg    <= '0;
            now_reg       <= '0;
            dt_reg        <= '0;
            dl_neg_reg    <= 1'b0;
            da_neg_reg    <= 1'b0;
            dl_reg        <= '0;
            da_reg        <= '0;
            sgn_reg       <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            na_reg        <= '0;
            nb_reg        <= 1'b0;
            i_reg         <= '0;
            j_reg         <= 1'b0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            c0_reg        <= '0;
            s0_reg        <= '0;
            cst_reg       <= 1'b0;
            cang_reg      <= '0;
            dst_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            px_out_reg    <= '0;
            py_out_reg    <= '0;
            hd_out_reg    <= '0;
            lin_out_reg   <= '0;
            ang_out_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_data;
            if (out_valid_reg && !pose_stall && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (mode)
                        begin
                            x_reg     <= '0;
                            y_reg     <= '0;
                            hd_reg    <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            now_reg    <= time_stamp;
                            sv_lin_reg <= fwd_speed;
                            sv_ang_reg <= yaw_rate;
                            state_reg  <= S_PREP;
                        end
                    end
                end
                S_PREP:
                begin
                    last_time_reg <= now_reg;
                    dt_reg        <= dt_sat;
                    dl_neg_reg    <= sv_lin_reg[31] != dneg;
                    da_neg_reg    <= sv_ang_reg[31] != dneg;
                    a_reg         <= {64'd0, vm};
                    b_reg         <= {32'd0, dt_sat};
                    na_reg        <= 2'd0;
                    nb_reg        <= 1'b0;
                    i_reg         <= '0;
                    j_reg         <= 1'b0;
                    acc_reg       <= '0;
                    job_reg       <= J_DL;
                    state_reg     <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= 64'(a_limb) * 64'(b_limb);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= acc_reg + shifted;
                    if (mul_last)
                        state_reg <= S_JOB;
                    else
                    begin
                        if (j_reg == nb_reg)
                        begin
                            j_reg <= 1'b0;
                            i_reg <= i_reg + 2'd1;
                        end
                        else
                            j_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_JOB:
                begin
                    i_reg   <= '0;
                    j_reg   <= 1'b0;
                    unique case (job_reg)
                        J_DL:
                        begin
                            dl_reg    <= dl_rnd[63:20];
                            a_reg     <= {64'd0, wm};
                            b_reg     <= {32'd0, dt_reg};
                            na_reg    <= 2'd0;
                            nb_reg    <= 1'b0;
                            acc_reg   <= '0;
                            job_reg   <= J_W;
                            state_reg <= S_MUL;
                        end
                        J_W:
                        begin
                            a_reg     <= {32'd0, acc_reg[63:0]};
                            b_reg     <= INV_TWO_PI_Q64;
                            na_reg    <= 2'd1;
                            nb_reg    <= 1'b1;
                            acc_reg   <= '0;
                            job_reg   <= J_K;
                            state_reg <= S_MUL;
                        end
                        J_K:
                        begin
                            da_reg    <= da_sat;
                            state_reg <= S_DECIDE;
                        end
                        J_MX:
                        begin
                            x_reg     <= add_pos(x_reg, sgn_reg, mid_mag);
                            sgn_reg   <= dl_neg_reg != sin_v[CW-1];
                            a_reg     <= {52'd0, dl_reg};
                            b_reg     <= {32'd0, mag_c(sin_v)};
                            na_reg    <= 2'd1;
                            nb_reg    <= 1'b0;
                            acc_reg   <= '0;
                            job_reg   <= J_MY;
                            state_reg <= S_MUL;
                        end
                        J_MY:
                        begin
                            y_reg     <= add_pos(y_reg, sgn_reg, mid_mag);
                            hd_reg    <= hd_reg + da_bits;
                            state_reg <= S_DONE;
                        end
                        J_AX1:
                        begin
                            a_reg     <= acc_reg[95:0];
                            b_reg     <= {32'd0, TWO_OVER_PI_Q32};
                            na_reg    <= 2'd2;
                            nb_reg    <= 1'b0;
                            acc_reg   <= '0;
                            job_reg   <= J_AX2;
                            state_reg <= S_MUL;
                        end
                        J_AX2:
                        begin
                            dst_reg   <= 1'b1;
                            state_reg <= S_DX;
                        end
                        J_AY1:
                        begin
                            a_reg     <= acc_reg[95:0];
                            b_reg     <= {32'd0, TWO_OVER_PI_Q32};
                            na_reg    <= 2'd2;
                            nb_reg    <= 1'b0;
                            acc_reg   <= '0;
                            job_reg   <= J_AY2;
                            state_reg <= S_MUL;
                        end
                        J_AY2:
                        begin
                            dst_reg   <= 1'b1;
                            state_reg <= S_DY;
                        end
                    endcase
                end
                S_DECIDE:
                begin
                    cst_reg <= 1'b1;
                    if (straight)
                    begin
                        cang_reg  <= dir;
                        state_reg <= S_CMID;
                    end
                    else
                    begin
                        cang_reg  <= hd_reg;
                        state_reg <= S_C0;
                    end
                end
                S_CMID:
                begin
                    cst_reg <= 1'b0;
                    if (cdone)
                    begin
                        sgn_reg   <= dl_neg_reg != cos_v[CW-1];
                        a_reg     <= {52'd0, dl_reg};
                        b_reg     <= {32'd0, mag_c(cos_v)};
                        na_reg    <= 2'd1;
                        nb_reg    <= 1'b0;
                        i_reg     <= '0;
                        j_reg     <= 1'b0;
                        acc_reg   <= '0;
                        job_reg   <= J_MX;
                        state_reg <= S_MUL;
                    end
                end
                S_C0:
                begin
                    cst_reg <= cdone;
                    if (cdone)
                    begin
                        c0_reg    <= cos_v;
                        s0_reg    <= sin_v;
                        cang_reg  <= hd_reg + da_bits;
                        state_reg <= S_C1;
                    end
                end
                S_C1:
                begin
                    cst_reg <= 1'b0;
                    if (cdone)
                    begin
                        sgn_reg   <= (dl_neg_reg != da_neg_reg) != dsx[CW];
                        a_reg     <= {52'd0, dl_reg};
                        b_reg     <= {32'd0, mag_d(dsx)};
                        na_reg    <= 2'd1;
                        nb_reg    <= 1'b0;
                        i_reg     <= '0;
                        j_reg     <= 1'b0;
                        acc_reg   <= '0;
                        job_reg   <= J_AX1;
                        state_reg <= S_MUL;
                    end
                end
                S_DX:
                begin
                    dst_reg <= 1'b0;
                    if (ddone)
                    begin
                        x_reg     <= add_pos(x_reg, sgn_reg, arc_mag);
                        sgn_reg   <= (dl_neg_reg != da_neg_reg) != dsy[CW];
                        a_reg     <= {52'd0, dl_reg};
                        b_reg     <= {32'd0, mag_d(dsy)};
                        na_reg    <= 2'd1;
                        nb_reg    <= 1'b0;
                        i_reg     <= '0;
                        j_reg     <= 1'b0;
                        acc_reg   <= '0;
                        job_reg   <= J_AY1;
                        state_reg <= S_MUL;
                    end
                end
                S_DY:
                begin
                    dst_reg <= 1'b0;
                    if (ddone)
                    begin
                        y_reg     <= add_pos(y_reg, sgn_reg, arc_mag);
                        hd_reg    <= hd_reg + da_bits;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !pose_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        px_out_reg    <= x_reg;
                        py_out_reg    <= y_reg;
                        hd_out_reg    <= $signed(hd_reg);
                        lin_out_reg   <= $signed(sv_lin_reg);
                        ang_out_reg   <= $signed(sv_ang_reg);
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign upd_stall    = (state_reg != S_IDLE);
    assign pose_valid   = out_valid_reg;
    assign pos_x        = px_out_reg;
    assign pos_y        = py_out_reg;
    assign heading      = hd_out_reg;
    assign last_linear  = lin_out_reg;
    assign last_angular = ang_out_reg;

endmodule

FILE: design/ppi_checker.sv
// Port-level assertions for the planar pose integrator, bound to the top level.
module ppi_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               upd_valid,
    input logic               upd_stall,
    input logic               mode,
    input logic               pose_valid,
    input logic               pose_stall,
    input logic signed [47:0] pos_x,
    input logic signed [47:0] pos_y,
    input logic signed [31:0] heading
);

    // An accepted request keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_valid && !upd_stall) |=> upd_stall)
        else $error("block ready right after accepting a request");

    // No result can come out of the cycle right after a request is accepted.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_valid && !upd_stall) |=> !$rose(pose_valid))
        else $error("result appeared too early");

    // A clear request with a free output shows the zero pose once S_DONE has loaded the output register.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_valid && !upd_stall && mode && !pose_valid) |-> ##2
        (pose_valid && pos_x == 48'sd0 && pos_y == 48'sd0 && heading == 32'sd0))
        else $error("clear request did not give the zero pose");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pose_valid && pose_stall) |=>
        (pose_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading)))
        else $error("stalled result changed");

endmodule

bind planar_pose_integrator_top ppi_checker u_ppi_checker (.*);

FILE: test/tb_planar_pose_integrator_top.sv
// Self-checking testbench for the planar pose integrator with a built-in pose predictor.
module tb_planar_pose_integrator_top;
    import ppi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_HI = 64'sd140737488355327;
    localparam longint POS_LO = -64'sd140737488355328;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 500;
    localparam int RANDOM_ITEMS = 850;
    localparam logic MODE_INTEGRATE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        logic [47:0]        ts;
    } odo_req_t;

    typedef struct packed {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [31:0] hdg;
        logic signed [31:0] lin;
        logic signed [31:0] ang;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic upd_valid = 1'b0;
    logic upd_stall;
    logic mode = 1'b0;
    logic signed [31:0] fwd_speed = '0;
    logic signed [31:0] yaw_rate = '0;
    logic [47:0] time_stamp = '0;
    logic pose_valid;
    logic pose_stall = 1'b0;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] last_linear;
    logic signed [31:0] last_angular;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;

    odo_req_t pending_reqs[$];
    pose_t expected_poses[$];
    int errors = 0;
    int poses_seen = 0;
    int idle_cycles = 0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    logic [47:0] cur_ts = '0;

    longint trk_x = 0;
    longint trk_y = 0;
    logic [31:0] trk_hdg = '0;
    logic [47:0] trk_time = '0;
    logic [31:0] trk_lin = '0;
    logic [31:0] trk_ang = '0;
    logic [15:0] trk_thr = 16'd1;

    planar_pose_integrator_top dut (
        .clk(clk), .rst_n(rst_n),
        .upd_valid(upd_valid), .upd_stall(upd_stall),
        .mode(mode), .fwd_speed(fwd_speed),
        .yaw_rate(yaw_rate), .time_stamp(time_stamp),
        .pose_valid(pose_valid), .pose_stall(pose_stall),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .last_linear(last_linear), .last_angular(last_angular),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void sin_cos(input logic [31:0] ang_in, output longint c,
                                    output longint s);
        logic [31:0] a;
        logic flip;
        longint x, y, z, xs, ys;
        a = ang_in;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip)
            a = a - 32'h80000000;
        z = longint'(signed'(a));
        x = longint'(CORDIC_X0);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({32'b0, ATAN_BAM[i]});
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({32'b0, ATAN_BAM[i]});
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint cap_signed(input bit neg, input logic [127:0] mag);
        logic [63:0] m;
        m = (mag > {65'b0, STEP_CAP}) ? {1'b0, STEP_CAP} : mag[63:0];
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint midpoint_step(input bit dl_neg, input logic [63:0] dl_mag,
                                             input longint f);
        logic [63:0] fm;
        logic [127:0] n;
        fm = (f < 0) ? -f : f;
        n = {64'b0, dl_mag} * {64'b0, fm};
        n = (n + (128'd1 << 29)) >> 30;
        return cap_signed(dl_neg != (f < 0), n);
    endfunction

    function automatic longint arc_step(input bit sgn, input logic [63:0] dl_mag,
                                        input longint ds, input logic [63:0] da_mag);
        logic [63:0] dm;
        logic [127:0] n;
        dm = (ds < 0) ? -ds : ds;
        n = {64'b0, dl_mag} * {64'b0, dm} * {96'b0, TWO_OVER_PI_Q32};
        n = n / {64'b0, da_mag};
        n = (n + (128'd1 << 31)) >> 32;
        return cap_signed(sgn != (ds < 0), n);
    endfunction

    function automatic longint clamp_pos(input longint p, input longint d);
        longint s;
        s = p + d;
        if (s > POS_HI)
            return POS_HI;
        if (s < POS_LO)
            return POS_LO;
        return s;
    endfunction

    task automatic integrate_pose(input odo_req_t r);
        logic [47:0] diff;
        logic [63:0] dt_mag, vm, wm, dl_mag, da_mag, half;
        logic [127:0] prod;
        logic [31:0] da_bits, dir;
        bit dt_neg, dl_neg, da_neg;
        longint c0, s0, c1, s1;
        pose_t p;
        if (r.mode == MODE_CLEAR)
        begin
            trk_x = 0;
            trk_y = 0;
            trk_hdg = '0;
        end
        else
        begin
            diff = r.ts - trk_time;
            dt_neg = diff[47];
            dt_mag = dt_neg ? (64'd1 << 48) - {16'b0, diff} : {16'b0, diff};
            if (dt_mag > 64'hFFFFFFFF)
                dt_mag = 64'hFFFFFFFF;
            dl_neg = (r.lin < 0) != dt_neg;
            da_neg = (r.ang < 0) != dt_neg;
            vm = (r.lin < 0) ? -longint'(r.lin) : longint'(r.lin);
            wm = (r.ang < 0) ? -longint'(r.ang) : longint'(r.ang);
            trk_lin = r.lin;
            trk_ang = r.ang;
            trk_time = r.ts;
            dl_mag = (vm * dt_mag + (64'd1 << 19)) >> 20;
            prod = {64'b0, wm * dt_mag} * {64'b0, INV_TWO_PI_Q64};
            prod = (prod + (128'd1 << (FRAC_BITS_DEF + 51))) >> (FRAC_BITS_DEF + 52);
            da_mag = (prod > {65'b0, STEP_CAP}) ? {1'b0, STEP_CAP} : prod[63:0];
            da_bits = da_neg ? -da_mag[31:0] : da_mag[31:0];
            if (da_mag == 0 || da_mag < {48'b0, trk_thr})
            begin
                half = da_neg ? (da_mag + 1) >> 1 : da_mag >> 1;
                dir = da_neg ? trk_hdg - half[31:0] : trk_hdg + half[31:0];
                sin_cos(dir, c0, s0);
                trk_x = clamp_pos(trk_x, midpoint_step(dl_neg, dl_mag, c0));
                trk_y = clamp_pos(trk_y, midpoint_step(dl_neg, dl_mag, s0));
            end
            else
            begin
                sin_cos(trk_hdg, c0, s0);
                sin_cos(trk_hdg + da_bits, c1, s1);
                trk_x = clamp_pos(trk_x, arc_step(dl_neg != da_neg, dl_mag, s1 - s0, da_mag));
                trk_y = clamp_pos(trk_y, arc_step(dl_neg != da_neg, dl_mag, c0 - c1, da_mag));
            end
            trk_hdg = trk_hdg + da_bits;
        end
        p.x = trk_x[47:0];
        p.y = trk_y[47:0];
        p.hdg = trk_hdg;
        p.lin = trk_lin;
        p.ang = trk_ang;
        expected_poses.push_back(p);
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return $urandom_range(20, 150);
        if (k < 7)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    // Request driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (upd_valid && !upd_stall)
                integrate_pose({mode, fwd_speed, yaw_rate, time_stamp});
            if (!upd_valid || !upd_stall)
            begin
                if ($urandom_range(0, 99) == 0)
                    send_calm = !send_calm;
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    upd_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    odo_req_t r;
                    r = pending_reqs.pop_front();
                    upd_valid <= 1'b1;
                    mode <= r.mode;
                    fwd_speed <= r.lin;
                    yaw_rate <= r.ang;
                    time_stamp <= r.ts;
                    send_gap = send_calm ? 0 : pick_gap();
                end
                else
                    upd_valid <= 1'b0;
            end
        end
    end

    // Result stall, including one long hold-off that lets the block back up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && poses_seen >= 60)
            begin
                hold_done = 1'b1;
                hold_left = 2500;
            end
            if ($urandom_range(0, 99) == 0)
                recv_calm = !recv_calm;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pose_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                pose_stall <= 1'b1;
            end
            else
            begin
                pose_stall <= 1'b0;
                recv_gap = recv_calm ? 0 : pick_gap();
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && pose_valid && !pose_stall)
        begin
            pose_t e;
            poses_seen = poses_seen + 1;
            if (expected_poses.size() == 0)
            begin
                $error("unexpected pose result");
                errors = errors + 1;
            end
            else
            begin
                e = expected_poses.pop_front();
                if (pos_x !== e.x)
                begin
                    $error("pos_x expected %0d actual %0d", e.x, pos_x);
                    errors = errors + 1;
                end
                if (pos_y !== e.y)
                begin
                    $error("pos_y expected %0d actual %0d", e.y, pos_y);
                    errors = errors + 1;
                end
                if (heading !== e.hdg)
                begin
                    $error("heading expected %0d actual %0d", e.hdg, heading);
                    errors = errors + 1;
                end
                if (last_linear !== e.lin)
                begin
                    $error("last_linear expected %0d actual %0d", e.lin, last_linear);
                    errors = errors + 1;
                end
                if (last_angular !== e.ang)
                begin
                    $error("last_angular expected %0d actual %0d", e.ang, last_angular);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog on handshake progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((upd_valid && !upd_stall) || (pose_valid && !pose_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_req(input logic m, input logic signed [31:0] lin,
                            input logic signed [31:0] ang, input logic [47:0] ts);
        odo_req_t r;
        r.mode = m;
        r.lin = lin;
        r.ang = ang;
        r.ts = ts;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_quiet();
        while (pending_reqs.size() > 0 || upd_valid || expected_poses.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        trk_thr = v;
    endtask

    task automatic random_batch(input int n);
        logic [47:0] step;
        logic signed [31:0] lin, ang;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0: push_req(MODE_CLEAR, $urandom, $urandom, 48'({$urandom, $urandom}));
                1, 2:
                begin
                    cur_ts = 48'({$urandom, $urandom});
                    push_req(MODE_INTEGRATE, $urandom, $urandom, cur_ts);
                end
                default:
                begin
                    step = $urandom_range(0, 3) == 0 ? 48'($urandom_range(0, 2000000))
                                                     : 48'($urandom_range(0, 30000));
                    lin = $signed($urandom) >>> $urandom_range(0, 14);
                    ang = $signed($urandom) >>> $urandom_range(0, 18);
                    if ($urandom_range(0, 9) == 0)
                        ang = '0;
                    cur_ts = cur_ts + step;
                    push_req(MODE_INTEGRATE, lin, ang, cur_ts);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        push_req(MODE_CLEAR, 32'sd0, 32'sd0, 48'd0);
        push_req(MODE_INTEGRATE, 32'sh7FFFFFFF, 32'sd0, 48'd1000);
        push_req(MODE_INTEGRATE, 32'sh80000000, 32'sd0, 48'd3000);
        push_req(MODE_INTEGRATE, 32'sd65536, 32'sh7FFFFFFF, 48'd4000);
        push_req(MODE_INTEGRATE, 32'sd65536, 32'sh80000000, 48'd5000);
        push_req(MODE_INTEGRATE, 32'sd65536, 32'sd1, 48'd5001);
        push_req(MODE_INTEGRATE, 32'sd65536, 32'sd102944, 48'd2000);
        push_req(MODE_INTEGRATE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 48'hFFFFFFFFFFFF);
        push_req(MODE_CLEAR, 32'sd0, 32'sd0, 48'd0);
        cur_ts = 48'hFFFFFFFFFFFF;
        for (int i = 0; i < 17; i++)
        begin
            cur_ts = cur_ts + 48'h100000000;
            push_req(MODE_INTEGRATE, 32'sh7FFFFFFF, 32'sd0, cur_ts);
        end
        wait_quiet();

        write_threshold(16'd0);
        push_req(MODE_CLEAR, 32'sd0, 32'sd0, 48'd0);
        random_batch(RANDOM_ITEMS / 4);
        wait_quiet();
        write_threshold(16'hFFFF);
        random_batch(RANDOM_ITEMS / 4);
        wait_quiet();
        write_threshold(16'($urandom));
        random_batch(RANDOM_ITEMS / 4);
        wait_quiet();
        write_threshold(16'd1);
        random_batch(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4));
        wait_quiet();

        if (errors == 0 && expected_poses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: filelist.f
design/ppi_pkg.sv
design/ppi_cordic.sv
design/ppi_divider.sv
design/planar_pose_integrator_top.sv
design/ppi_checker.sv
test/tb_planar_pose_integrator_top.sv
